[rtl/core/h264fu_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// h264fu_pkg
// Types and constants shared by the RTP FU-A packetizer modules.
// ---------------------------------------------------------------------------
package h264fu_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] RTP_V2     = 8'h80;
  localparam logic [7:0] NRI_MASK   = 8'h60;
  localparam logic [7:0] TYPE_MASK  = 8'h1f;
  localparam logic [7:0] FU_A_TYPE  = 8'd28;
  localparam logic [7:0] FU_S_BIT   = 8'h80;
  localparam logic [7:0] FU_E_BIT   = 8'h40;
  localparam logic [6:0] PT_MASK    = 7'h7f;
  localparam logic [7:0] BYTE_MASK  = 8'hff;

  // byte offsets inside a packet prefix
  localparam logic [3:0] POS_FU_IND = 4'd12;
  localparam logic [3:0] POS_FU_HDR = 4'd13;
  localparam logic [3:0] POS_DATA   = 4'd14;

  typedef enum logic [1:0] {
    REG_SSRC = 2'd0,
    REG_PT   = 2'd1,
    REG_MAXP = 2'd2,
    REG_FSEQ = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [23:0] nalu_length;
    logic [31:0] media_timestamp;
    logic        access_unit_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] sync_source_id;
    logic [6:0]  rtp_pt;
    logic [10:0] max_payload;
    logic [15:0] first_sequence;
    logic        seq_load;
  } cfg_t;

  // one queued transfer job: optional RTP header, optional FU bytes, one data byte
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last;
    logic        hdr;
    logic        fu;
    logic        mark;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [15:0] seq;
    logic [31:0] ts;
  } job_t;

endpackage
`default_nettype wire

[rtl/core/h264fu_regs.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// h264fu_regs
// APB-style register file: SSRC, payload type, max payload, first sequence.
// ---------------------------------------------------------------------------
module h264fu_regs
  import h264fu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  logic [31:0] ssrc_r, ssrc_nxt;
  logic [6:0]  pt_r, pt_nxt;
  logic [10:0] maxp_r, maxp_nxt;
  logic [15:0] fseq_r, fseq_nxt;
  logic        load_nxt;
  logic        wr;
  reg_idx_t    idx;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    ssrc_nxt = ssrc_r;
    pt_nxt   = pt_r;
    maxp_nxt = maxp_r;
    fseq_nxt = fseq_r;
    load_nxt = 1'b0;
    if (wr) begin
      case (idx)
        REG_SSRC: ssrc_nxt = cfg_pwdata;
        REG_PT:   pt_nxt   = cfg_pwdata[6:0] & PT_MASK;
        REG_MAXP: maxp_nxt = cfg_pwdata[10:0];
        REG_FSEQ: begin
          fseq_nxt = cfg_pwdata[15:0];
          load_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SSRC: cfg_prdata = ssrc_r;
      REG_PT:   cfg_prdata = {25'd0, pt_r};
      REG_MAXP: cfg_prdata = {21'd0, maxp_r};
      REG_FSEQ: cfg_prdata = {16'd0, fseq_r};
      default:  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ssrc_r <= '0;
      pt_r   <= 7'd96;
      maxp_r <= 11'd1200;
      fseq_r <= '0;
    end else begin
      ssrc_r <= ssrc_nxt;
      pt_r   <= pt_nxt;
      maxp_r <= maxp_nxt;
      fseq_r <= fseq_nxt;
    end
  end

  // counter reload reaches the front at the write edge itself
  assign cfg.sync_source_id = ssrc_r;
  assign cfg.rtp_pt         = pt_r;
  assign cfg.max_payload    = maxp_r;
  assign cfg.first_sequence = fseq_nxt;
  assign cfg.seq_load       = load_nxt;

endmodule
`default_nettype wire

[rtl/core/h264fu_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// h264fu_front
// Classifies each NAL byte, tracks unit/fragment state, builds queue jobs.
// ---------------------------------------------------------------------------
module h264fu_front
  import h264fu_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     accept,
  input  wire in_item_t in_data,
  output logic          push,
  output job_t          job
);

  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [10:0]            chunk_r, chunk_nxt;
  logic                   frag_r, frag_nxt;
  logic [7:0]             nal_r, nal_nxt;
  logic [31:0]            ts_r, ts_nxt;
  logic                   mark_r, mark_nxt;
  logic                   first_r, first_nxt;
  logic [10:0]            size_r, size_nxt;
  logic [15:0]            seq_r, seq_nxt;

  logic [LENGTH_BITS-1:0] len_w, len0, rem_dec;
  logic [10:0]            size_in, chunk_inc;
  logic                   last_frag, seq_inc;

  always_comb begin
    len_w     = LENGTH_BITS'(in_data.nalu_length);
    len0      = (len_w == '0) ? LENGTH_BITS'(1) : len_w;
    size_in   = (cfg.max_payload == '0) ? 11'd1 : cfg.max_payload;
    rem_dec   = rem_r - LENGTH_BITS'(1);
    chunk_inc = chunk_r + 11'd1;
    last_frag = rem_r <= LENGTH_BITS'(size_r);

    rem_nxt   = rem_r;
    chunk_nxt = chunk_r;
    frag_nxt  = frag_r;
    nal_nxt   = nal_r;
    ts_nxt    = ts_r;
    mark_nxt  = mark_r;
    first_nxt = first_r;
    size_nxt  = size_r;
    seq_inc   = 1'b0;
    push      = 1'b0;

    job.data_byte = in_data.data_byte & BYTE_MASK;
    job.last      = 1'b0;
    job.hdr       = 1'b0;
    job.fu        = 1'b0;
    job.mark      = 1'b0;
    job.fu_ind    = (nal_r & NRI_MASK) | FU_A_TYPE;
    job.fu_hdr    = (nal_r & TYPE_MASK) | (first_r ? FU_S_BIT : 8'h00)
                    | (last_frag ? FU_E_BIT : 8'h00);
    job.seq       = seq_r;
    job.ts        = ts_r;

    if (accept) begin
      if (rem_r == '0) begin
        // first byte of a unit
        ts_nxt    = in_data.media_timestamp;
        mark_nxt  = in_data.access_unit_end;
        nal_nxt   = in_data.data_byte;
        size_nxt  = size_in;
        rem_nxt   = len0 - LENGTH_BITS'(1);
        chunk_nxt = '0;
        if (len0 <= LENGTH_BITS'(size_in)) begin
          frag_nxt = 1'b0;
          push     = 1'b1;
          seq_inc  = 1'b1;
          job.hdr  = 1'b1;
          job.mark = in_data.access_unit_end;
          job.ts   = in_data.media_timestamp;
          job.last = (len0 == LENGTH_BITS'(1));
        end else begin
          frag_nxt  = 1'b1;
          first_nxt = 1'b1;
        end
      end else begin
        rem_nxt = rem_dec;
        push    = 1'b1;
        if (!frag_r) begin
          job.last = (rem_dec == '0);
        end else begin
          if (chunk_r == '0) begin
            job.hdr   = 1'b1;
            job.fu    = 1'b1;
            job.mark  = mark_r & last_frag;
            seq_inc   = 1'b1;
            first_nxt = 1'b0;
          end
          if (chunk_inc >= size_r || rem_dec == '0) begin
            chunk_nxt = '0;
            job.last  = 1'b1;
          end else begin
            chunk_nxt = chunk_inc;
          end
        end
      end
    end

    if (cfg.seq_load) begin
      seq_nxt = cfg.first_sequence;
    end else if (seq_inc) begin
      seq_nxt = seq_r + 16'd1;
    end else begin
      seq_nxt = seq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      chunk_r <= '0;
      frag_r  <= 1'b0;
      nal_r   <= '0;
      ts_r    <= '0;
      mark_r  <= 1'b0;
      first_r <= 1'b0;
      size_r  <= '0;
      seq_r   <= '0;
    end else begin
      rem_r   <= rem_nxt;
      chunk_r <= chunk_nxt;
      frag_r  <= frag_nxt;
      nal_r   <= nal_nxt;
      ts_r    <= ts_nxt;
      mark_r  <= mark_nxt;
      first_r <= first_nxt;
      size_r  <= size_nxt;
      seq_r   <= seq_nxt;
    end
  end

`ifndef ASSERT_OFF
  // an open fragment implies fragment mode with bytes still to come
  a_chunk_open: assert property (@(posedge clk) disable iff (!rst_n)
    (chunk_r != '0) |-> (frag_r && rem_r != '0))
    else $error("open fragment outside fragment mode");
`endif

endmodule
`default_nettype wire

[rtl/core/h264fu_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// h264fu_queue
// Small register FIFO of jobs between front and back.
// ---------------------------------------------------------------------------
module h264fu_queue
  import h264fu_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output job_t      head_job
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue underflow");
`endif

endmodule
`default_nettype wire

[rtl/core/h264fu_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// h264fu_back
// Serializes queued jobs into packet bytes through an output register.
// ---------------------------------------------------------------------------
module h264fu_back
  import h264fu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic head_valid,
  input  wire job_t head_job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  logic [3:0] pos_r, pos_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       ol_r, ol_nxt;
  logic       load, is_data;
  logic [7:0] cur_byte;

  assign load = !ov_r || out_ready;

  always_comb begin
    is_data = !head_job.hdr || (pos_r == POS_FU_IND && !head_job.fu)
              || (pos_r == POS_DATA);
    if (!head_job.hdr) begin
      cur_byte = head_job.data_byte;
    end else begin
      case (pos_r)
        4'd0:       cur_byte = RTP_V2;
        4'd1:       cur_byte = {head_job.mark, cfg.rtp_pt & PT_MASK};
        4'd2:       cur_byte = head_job.seq[15:8];
        4'd3:       cur_byte = head_job.seq[7:0];
        4'd4:       cur_byte = head_job.ts[31:24];
        4'd5:       cur_byte = head_job.ts[23:16];
        4'd6:       cur_byte = head_job.ts[15:8];
        4'd7:       cur_byte = head_job.ts[7:0];
        4'd8:       cur_byte = cfg.sync_source_id[31:24];
        4'd9:       cur_byte = cfg.sync_source_id[23:16];
        4'd10:      cur_byte = cfg.sync_source_id[15:8];
        4'd11:      cur_byte = cfg.sync_source_id[7:0];
        POS_FU_IND: cur_byte = head_job.fu ? head_job.fu_ind : head_job.data_byte;
        POS_FU_HDR: cur_byte = head_job.fu_hdr;
        default:    cur_byte = head_job.data_byte;
      endcase
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    ov_nxt  = ov_r;
    ob_nxt  = ob_r;
    ol_nxt  = ol_r;
    pop     = 1'b0;
    if (load) begin
      ov_nxt = head_valid;
      if (head_valid) begin
        ob_nxt  = cur_byte;
        ol_nxt  = is_data & head_job.last;
        pop     = is_data;
        pos_nxt = is_data ? 4'd0 : pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid            = ov_r;
  assign out_data.out_byte    = ob_r;
  assign out_data.packet_last = ol_r;

`ifndef ASSERT_OFF
  // mid-job the job must still sit at the queue head
  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != 4'd0) |-> head_valid)
    else $error("job left queue before its data byte");
`endif

endmodule
`default_nettype wire

[rtl/core/h264_rtp_fu_a_packetizer.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// h264_rtp_fu_a_packetizer
// H.264 NAL unit to RTP packet byte stream, single packet or FU-A fragments.
// ---------------------------------------------------------------------------
//
//  channel | ports                          | transfer when
//  --------+--------------------------------+------------------------------
//  input   | in_valid in_ready in_data      | in_valid & in_ready
//  output  | out_valid out_ready out_data   | out_valid & out_ready
//  config  | cfg_psel .. cfg_pready (APB)   | psel & penable & pwrite
//
//  Each payload byte is one queue job. A job that opens a packet is preceded
//  by the 12 RTP header bytes, plus FU indicator and FU header for an FU-A
//  fragment, all emitted by the back end's byte serializer. The unit's NAL
//  header byte of a fragmented unit is absorbed with no output.
//  Reset is synchronous and active low; no clearing pass.
//  The job queue decouples sides: input stalls only when the queue is full,
//  output stalls hold the output register while the front keeps filling.
//
module h264_rtp_fu_a_packetizer
  import h264fu_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t cfg;
  job_t push_job, head_job;
  logic push, pop, full, head_valid, accept;

  // queue full is the only reason to refuse a byte
  assign in_ready = !full;
  assign accept   = in_valid & in_ready;

  h264fu_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // front: unit/fragment bookkeeping, sequence numbering, job build
  h264fu_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (accept),
    .in_data (in_data),
    .push    (push),
    .job     (push_job)
  );

  h264fu_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: expands each job into header, FU bytes and the data byte
  h264fu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
